[rtl/vst_pkg.sv]
// ----------------------------------------------------------------------------
// vst_pkg
// Shared types, widths, register codes and the quarter-wave sine table for
// the vibrato sine tone generator.
// ----------------------------------------------------------------------------
`default_nettype none

package vst_pkg;

	// sizing
	localparam int SINE_ADDR_BITS = 10;
	localparam int PHASE_BITS     = 32;
	localparam int SAMPLE_BITS    = 16;

	localparam int HALF_N    = 1 << (SINE_ADDR_BITS - 1);
	localparam int QUARTER_N = 1 << (SINE_ADDR_BITS - 2);

	// field and register widths
	localparam int STEP_W  = 32;
	localparam int SWING_W = 31;
	localparam int AMP_W   = 15;
	localparam int MAG_W   = 15;
	localparam int DATA_W  = 32;
	localparam int PADDR_W = 4;
	localparam int SAT_W   = SAMPLE_BITS + MAG_W + 1;

	// register reset values
	localparam logic [STEP_W-1:0]  BASE_STEP_RST  = 32'd88583700;
	localparam logic [SWING_W-1:0] SWING_STEP_RST = 31'd24159191;
	localparam logic [STEP_W-1:0]  LFO_STEP_RST   = 32'd93952;
	localparam logic [AMP_W-1:0]   AMPLITUDE_RST  = 15'd5000;

	// register index codes (paddr[3:2])
	typedef enum logic [1:0] {
		REG_BASE_STEP  = 2'd0,
		REG_SWING_STEP = 2'd1,
		REG_LFO_STEP   = 2'd2,
		REG_AMPLITUDE  = 2'd3
	} reg_idx_t;

	// configuration bundle
	typedef struct packed {
		logic [STEP_W-1:0]  base_step;
		logic [SWING_W-1:0] swing_step;
		logic [STEP_W-1:0]  lfo_step;
		logic [AMP_W-1:0]   amplitude;
	} cfg_t;

	// sine value in sign / magnitude form
	typedef struct packed {
		logic             neg;
		logic [MAG_W-1:0] mag;
	} sine_t;

	// quarter-wave magnitude, Q30 Taylor series in Horner form, rounded to Q15
	function automatic logic [MAG_W-1:0] sine_q15_mag(input int unsigned q);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] one;
		one = 64'd1 << 30;
		x   = (64'(q) * 64'd1686629713) >> (SINE_ADDR_BITS - 2);
		x2  = (x * x) >> 30;
		t   = one - x2 / 64'd72;
		t   = one - ((x2 * t) >> 30) / 64'd42;
		t   = one - ((x2 * t) >> 30) / 64'd20;
		t   = one - ((x2 * t) >> 30) / 64'd6;
		s   = (x * t) >> 30;
		s   = (s + 64'd16384) >> 15;
		if (s > 64'd32767)
			s = 64'd32767;
		return s[MAG_W-1:0];
	endfunction

	typedef logic [MAG_W-1:0] qtab_t [QUARTER_N];

	function automatic qtab_t build_qtab();
		qtab_t tab;
		for (int i = 0; i < QUARTER_N; i++)
			tab[i] = sine_q15_mag(i);
		return tab;
	endfunction

	// table covers the quarter below the peak, the peak is a constant of its own
	localparam qtab_t            QUARTER_TAB = build_qtab();
	localparam logic [MAG_W-1:0] SINE_PEAK   = sine_q15_mag(QUARTER_N);

endpackage

`default_nettype wire

[rtl/vibrato_sine_tone_generator.sv]
// ----------------------------------------------------------------------------
// vibrato_sine_tone_generator
// Direct digital synthesis sine tone with LFO vibrato: one signed sample per
// accepted word, amplitude times the sine of the tone phase.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------
//  in      | to block  | in_valid / in_stall | restart
//  out     | from block| out_valid / out_stall | sample (signed 16)
//  config  | to block  | psel/penable/pready | paddr, pwdata, prdata
//
//  One word per cycle sustained while out_stall is low; each sample passes the
//  input register, then the result register, after its word is accepted.
//  The tone/LFO phase update is a registered feedback loop: registered LFO sine,
//  one 31x15 multiply and two adds back into the tone phase register.
//  out_stall holds the result register and stalls the input only when both
//  stages are full. Reset clears the phases and restores register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module vibrato_sine_tone_generator
	import vst_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic                     restart,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic signed [SAMPLE_BITS-1:0] sample,
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic     [PADDR_W-1:0]   paddr,
	input  wire logic     [DATA_W-1:0]    pwdata,
	output logic          [DATA_W-1:0]    prdata,
	output logic                          pready
);

	cfg_t                      cfg;
	logic                      accept;
	logic [SINE_ADDR_BITS-1:0] tone_addr;

	assign pready = 1'b1;

	// configuration registers
	vst_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// phase accumulators
	vst_phase_acc u_phase (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.restart   (restart),
		.cfg       (cfg),
		.tone_addr (tone_addr)
	);

	// sample pipeline and handshake
	vst_sample_stage u_sample (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.accept    (accept),
		.tone_addr (tone_addr),
		.amplitude (cfg.amplitude),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sample    (sample)
	);

endmodule

`default_nettype wire

[rtl/vst_sine_lookup.sv]
// ----------------------------------------------------------------------------
// vst_sine_lookup
// Folds a full-turn sine address onto the quarter-wave table and returns the
// sine as sign and magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module vst_sine_lookup
	import vst_pkg::*;
(
	input  wire logic [SINE_ADDR_BITS-1:0] addr,
	output sine_t                          sine
);

	logic [SINE_ADDR_BITS-2:0] h;
	logic [SINE_ADDR_BITS-1:0] mirror;
	logic [SINE_ADDR_BITS-2:0] q;
	logic                      peak;

	// fold the second quarter of each half back onto the first
	assign h      = addr[SINE_ADDR_BITS-2:0];
	assign mirror = SINE_ADDR_BITS'(HALF_N) - {1'b0, h};
	assign q      = (h <= (SINE_ADDR_BITS-1)'(QUARTER_N)) ? h : mirror[SINE_ADDR_BITS-2:0];
	assign peak   = (q == (SINE_ADDR_BITS-1)'(QUARTER_N));

	// second half of the turn is negative
	assign sine.neg = addr[SINE_ADDR_BITS-1];
	assign sine.mag = peak ? SINE_PEAK : QUARTER_TAB[q[SINE_ADDR_BITS-3:0]];

endmodule

`default_nettype wire

[rtl/vst_apb_regs.sv]
// ----------------------------------------------------------------------------
// vst_apb_regs
// APB-style configuration registers: base step, swing step, LFO step and
// amplitude.
// ----------------------------------------------------------------------------
`default_nettype none

module vst_apb_regs
	import vst_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0]  pwdata,
	output logic      [DATA_W-1:0]  prdata,
	output cfg_t                    cfg
);

	logic [STEP_W-1:0]  base_step_q;
	logic [SWING_W-1:0] swing_step_q;
	logic [STEP_W-1:0]  lfo_step_q;
	logic [AMP_W-1:0]   amplitude_q;
	logic               wr_en;
	reg_idx_t           idx;

	assign wr_en = psel && penable && pwrite;
	assign idx   = reg_idx_t'(paddr[PADDR_W-1:2]);

	// register writes in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_step_q  <= BASE_STEP_RST;
			swing_step_q <= SWING_STEP_RST;
			lfo_step_q   <= LFO_STEP_RST;
			amplitude_q  <= AMPLITUDE_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_BASE_STEP:  base_step_q  <= pwdata;
				REG_SWING_STEP: swing_step_q <= pwdata[SWING_W-1:0];
				REG_LFO_STEP:   lfo_step_q   <= pwdata;
				REG_AMPLITUDE:  amplitude_q  <= pwdata[AMP_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (idx)
			REG_BASE_STEP:  prdata = base_step_q;
			REG_SWING_STEP: prdata = DATA_W'(swing_step_q);
			REG_LFO_STEP:   prdata = lfo_step_q;
			REG_AMPLITUDE:  prdata = DATA_W'(amplitude_q);
			default:        prdata = '0;
		endcase
	end

	assign cfg.base_step  = base_step_q;
	assign cfg.swing_step = swing_step_q;
	assign cfg.lfo_step   = lfo_step_q;
	assign cfg.amplitude  = amplitude_q;

endmodule

`default_nettype wire

[rtl/vst_phase_acc.sv]
// ----------------------------------------------------------------------------
// vst_phase_acc
// Tone and LFO phase accumulators. The LFO sine of the current LFO phase is
// kept in a register so the tone step needs only a multiply and two adds.
// ----------------------------------------------------------------------------
`default_nettype none

module vst_phase_acc
	import vst_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      accept,
	input  wire logic                      restart,
	input  wire cfg_t                      cfg,
	output logic      [SINE_ADDR_BITS-1:0] tone_addr
);

	localparam int PROD_W = SWING_W + MAG_W;

	logic [PHASE_BITS-1:0] tone_q;
	logic [PHASE_BITS-1:0] lfo_q;
	sine_t                 lfo_sine_q;

	logic [PHASE_BITS-1:0] tone_cur;
	logic [PHASE_BITS-1:0] lfo_cur;
	logic [PHASE_BITS-1:0] lfo_next;
	logic [PHASE_BITS-1:0] tone_next;
	logic [PHASE_BITS-1:0] step;
	logic [PHASE_BITS-1:0] base_ext;
	logic [PHASE_BITS-1:0] dev_ext;
	logic [PROD_W-1:0]     dev_prod;
	logic [SWING_W-1:0]    dev;
	sine_t                 lfo_sine_next;

	// restart zeroes both phases ahead of this word
	assign tone_cur = restart ? '0 : tone_q;
	assign lfo_cur  = restart ? '0 : lfo_q;
	assign tone_addr = tone_cur[PHASE_BITS-1 -: SINE_ADDR_BITS];

	// lfo advance and sine of the new lfo phase
	assign lfo_next = lfo_cur + PHASE_BITS'(cfg.lfo_step);

	vst_sine_lookup u_lfo_sine (
		.addr (lfo_next[PHASE_BITS-1 -: SINE_ADDR_BITS]),
		.sine (lfo_sine_next)
	);

	// step deviation, truncated toward zero; zero phase gives zero sine
	assign dev_prod = PROD_W'(cfg.swing_step) * PROD_W'(lfo_sine_q.mag);
	assign dev      = restart ? '0 : dev_prod[PROD_W-1:MAG_W];
	assign base_ext = PHASE_BITS'(cfg.base_step);
	assign dev_ext  = PHASE_BITS'(dev);
	assign step     = lfo_sine_q.neg ? (base_ext - dev_ext) : (base_ext + dev_ext);
	assign tone_next = tone_cur + step;

	// phase state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_q     <= '0;
			lfo_q      <= '0;
			lfo_sine_q <= '0;
		end else if (accept) begin
			tone_q     <= tone_next;
			lfo_q      <= lfo_next;
			lfo_sine_q <= lfo_sine_next;
		end
	end

endmodule

`default_nettype wire

[rtl/vst_sample_stage.sv]
// ----------------------------------------------------------------------------
// vst_sample_stage
// Two-register sample path: the tone address is captured on input, then the
// sine is looked up, scaled by the amplitude and saturated into the result.
// ----------------------------------------------------------------------------
`default_nettype none

module vst_sample_stage
	import vst_pkg::*;
(
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	output logic                               accept,
	input  wire logic        [SINE_ADDR_BITS-1:0] tone_addr,
	input  wire logic        [AMP_W-1:0]       amplitude,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed      [SAMPLE_BITS-1:0] sample
);

	localparam int AP_W = AMP_W + MAG_W;
	localparam logic [SAT_W-1:0] POS_LIM = SAT_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
	localparam logic [SAT_W-1:0] NEG_LIM = SAT_W'(64'd1 << (SAMPLE_BITS - 1));

	logic                      vld_s1;
	logic [SINE_ADDR_BITS-1:0] addr_s1;
	logic                      vld_s2;
	logic [SAMPLE_BITS-1:0]    sample_s2;

	logic                      adv_s1;
	logic                      adv_s2;
	sine_t                     tone_sine;
	logic [AP_W-1:0]           amp_prod;
	logic [SAT_W-1:0]          mag_w;
	logic [SAT_W-1:0]          mag_sat;
	logic [SAMPLE_BITS-1:0]    sample_d;

	// flow control: a stage moves when the one after it can take a word
	assign adv_s2   = !vld_s2 || !out_stall;
	assign adv_s1   = !vld_s1 || adv_s2;
	assign in_stall = !adv_s1;
	assign accept   = in_valid && adv_s1;

	// tone sine and amplitude scaling, truncated toward zero
	vst_sine_lookup u_tone_sine (
		.addr (addr_s1),
		.sine (tone_sine)
	);

	assign amp_prod = AP_W'(amplitude) * AP_W'(tone_sine.mag);
	assign mag_w    = SAT_W'(amp_prod[AP_W-1:MAG_W]);

	// saturate to the sample range, then apply the sign
	always_comb begin
		mag_sat = mag_w;
		if (tone_sine.neg) begin
			if (mag_w > NEG_LIM)
				mag_sat = NEG_LIM;
		end else begin
			if (mag_w > POS_LIM)
				mag_sat = POS_LIM;
		end
		sample_d = tone_sine.neg ? -mag_sat[SAMPLE_BITS-1:0] : mag_sat[SAMPLE_BITS-1:0];
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (adv_s1)
				vld_s1 <= in_valid;
			if (adv_s2)
				vld_s2 <= vld_s1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept)
			addr_s1 <= tone_addr;
		if (adv_s2 && vld_s1)
			sample_s2 <= sample_d;
	end

	assign out_valid = vld_s2;
	assign sample    = sample_s2;

endmodule

`default_nettype wire

[rtl/vst_checker.sv]
// ----------------------------------------------------------------------------
// vst_checker
// Port-level checks of the tone generator, bound onto the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module vst_checker
	import vst_pkg::*;
(
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_stall,
	input wire logic                          restart,
	input wire logic                          out_valid,
	input wire logic                          out_stall,
	input wire logic signed [SAMPLE_BITS-1:0] sample
);

	// a stalled result stays valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	// a stalled result keeps its value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(sample))
		else $error("result word changed while stalled");

	// with the result register empty the input is never stalled
	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	// an accepted word passes the input register, then the result register, to the output when not blocked
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 (!out_valid || !out_stall) |=> out_valid)
		else $error("accepted word did not reach the output");

	// a restart word starts from zero phase and gives a zero sample
	a_restart_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && restart) ##1 (!out_valid || !out_stall)
		|=> (out_valid && sample == '0))
		else $error("restart word gave a nonzero sample");

endmodule

bind vibrato_sine_tone_generator vst_checker u_chk (.*);

`default_nettype wire
